>>> rtl/core/sdf_pkg.sv
package sdf_pkg;

    localparam int MAX_FIELD_DEF = 63;
    localparam int BIN_W         = 32;
    localparam int NUM_DIGITS    = 10;
    localparam int BCD_W         = 4 * NUM_DIGITS;
    localparam int CNT_W         = $clog2(BIN_W);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ADJUST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_FILL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_ALWAYS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_SIGN    = 3'd5;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    localparam logic [6:0] PRECISION_NONE = 7'h7F;

    typedef struct packed {
        logic [5:0] min_width;
        logic [6:0] precision;
        logic       left_adjust;
        logic       zero_fill;
        logic       sign_always;
        logic [7:0] positive_sign_char;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SETUP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic setup;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic at_last;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/sdf_cfg.sv
module sdf_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [sdf_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [sdf_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output sdf_pkg::cfg_t                    cfg
);
    import sdf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_MIN_WIDTH:   cfg_next.min_width          = cfg_wr_data[5:0];
                CFG_PRECISION:   cfg_next.precision          = cfg_wr_data[6:0];
                CFG_LEFT_ADJUST: cfg_next.left_adjust        = cfg_wr_data[0];
                CFG_ZERO_FILL:   cfg_next.zero_fill          = cfg_wr_data[0];
                CFG_SIGN_ALWAYS: cfg_next.sign_always        = cfg_wr_data[0];
                CFG_POS_SIGN:    cfg_next.positive_sign_char = cfg_wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_width          <= 6'd0;
            cfg_reg.precision          <= PRECISION_NONE;
            cfg_reg.left_adjust        <= 1'b0;
            cfg_reg.zero_fill          <= 1'b0;
            cfg_reg.sign_always        <= 1'b0;
            cfg_reg.positive_sign_char <= CHAR_PLUS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/sdf_ctrl.sv
module sdf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sdf_pkg::sts_t  sts,
    output sdf_pkg::cmd_t  cmd
);
    import sdf_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (cnt_reg == CNT_W'(BIN_W - 1)) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.empty) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free && sts.at_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                cnt_next = '0;
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = !sts.empty && sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/core/sdf_dp.sv
module sdf_dp #(
    parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sdf_pkg::cfg_t              cfg,
    input  sdf_pkg::cmd_t              cmd,
    output sdf_pkg::sts_t              sts,
    input  logic [sdf_pkg::BIN_W-1:0]  s_value,
    output logic                       m_valid,
    output logic [7:0]                 m_char,
    output logic                       m_last,
    input  logic                       m_ready
);
    import sdf_pkg::*;

    localparam int CW       = $clog2(MAX_FIELD + 1);
    localparam int XW       = (CW > 6) ? CW + 1 : 7;
    localparam int PREC_CAP = (MAX_FIELD - 1 < 62) ? MAX_FIELD - 1 : 62;

    logic [BIN_W-1:0] bin_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic [CW-1:0]    b1_reg;
    logic [CW-1:0]    b2_reg;
    logic [CW-1:0]    b3_reg;
    logic [CW-1:0]    b4_reg;
    logic [CW-1:0]    total_reg;
    logic [CW-1:0]    pos_reg;
    logic             valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;

    logic [BCD_W-1:0] bcd_adj;
    logic [XW-1:0]    nd;
    logic [XW-1:0]    prec_c;
    logic [XW-1:0]    width_c;
    logic [XW-1:0]    sgn;
    logic [XW-1:0]    zeros;
    logic [XW-1:0]    body;
    logic [XW-1:0]    pad;
    logic [XW-1:0]    lead;
    logic [XW-1:0]    trail;
    logic [XW-1:0]    b1_x;
    logic [XW-1:0]    b2_x;
    logic [XW-1:0]    b3_x;
    logic [XW-1:0]    b4_x;
    logic [XW-1:0]    total_x;
    logic             has_prec;
    logic             has_sign;
    logic [CW-1:0]    dig_off;
    logic [3:0]       dig_val;
    logic [7:0]       char_now;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        has_prec = !cfg.precision[6];
        has_sign = neg_reg || cfg.sign_always;
        nd       = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                nd = XW'(i + 1);
            end
        end
        if (has_prec && cfg.precision[5:0] == 6'd0 && zero_reg) begin
            nd = '0;
        end else if (nd == '0) begin
            nd = XW'(1);
        end
        prec_c = XW'(cfg.precision[5:0]);
        if (prec_c > XW'(PREC_CAP)) begin
            prec_c = XW'(PREC_CAP);
        end
        width_c = XW'(cfg.min_width);
        if (width_c > XW'(MAX_FIELD)) begin
            width_c = XW'(MAX_FIELD);
        end
        sgn   = has_sign ? XW'(1) : '0;
        zeros = (has_prec && prec_c > nd) ? prec_c - nd : '0;
        body  = sgn + zeros + nd;
        pad   = (width_c > body) ? width_c - body : '0;
        lead  = '0;
        trail = '0;
        if (cfg.left_adjust) begin
            trail = pad;
        end else if (cfg.zero_fill && !has_prec) begin
            zeros = zeros + pad;
        end else begin
            lead = pad;
        end
        b1_x    = lead;
        b2_x    = b1_x + sgn;
        b3_x    = b2_x + zeros;
        b4_x    = b3_x + nd;
        total_x = b4_x + trail;
    end

    always_comb begin
        dig_off = b4_reg - pos_reg - CW'(1);
        case (dig_off[3:0])
            4'd0:    dig_val = bcd_reg[3:0];
            4'd1:    dig_val = bcd_reg[7:4];
            4'd2:    dig_val = bcd_reg[11:8];
            4'd3:    dig_val = bcd_reg[15:12];
            4'd4:    dig_val = bcd_reg[19:16];
            4'd5:    dig_val = bcd_reg[23:20];
            4'd6:    dig_val = bcd_reg[27:24];
            4'd7:    dig_val = bcd_reg[31:28];
            4'd8:    dig_val = bcd_reg[35:32];
            4'd9:    dig_val = bcd_reg[39:36];
            default: dig_val = 4'd0;
        endcase
        if (pos_reg < b1_reg) begin
            char_now = CHAR_SPACE;
        end else if (pos_reg < b2_reg) begin
            char_now = neg_reg ? CHAR_MINUS : cfg.positive_sign_char;
        end else if (pos_reg < b3_reg) begin
            char_now = CHAR_ZERO;
        end else if (pos_reg < b4_reg) begin
            char_now = CHAR_ZERO | {4'd0, dig_val};
        end else begin
            char_now = CHAR_SPACE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg  <= s_value[BIN_W-1];
            zero_reg <= (s_value == '0);
            bin_reg  <= s_value[BIN_W-1] ? (BIN_W'(0) - s_value) : s_value;
            bcd_reg  <= '0;
        end else if (cmd.step) begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_reg <= {bin_reg[BIN_W-2:0], 1'b0};
        end
        if (cmd.setup) begin
            b1_reg    <= b1_x[CW-1:0];
            b2_reg    <= b2_x[CW-1:0];
            b3_reg    <= b3_x[CW-1:0];
            b4_reg    <= b4_x[CW-1:0];
            total_reg <= total_x[CW-1:0];
            pos_reg   <= '0;
        end else if (cmd.emit) begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.emit) begin
            char_reg <= char_now;
            last_reg <= (pos_reg == total_reg - CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign sts.empty    = (total_reg == '0);
    assign sts.at_last  = (pos_reg == total_reg - CW'(1));
    assign sts.out_free = !valid_reg || m_ready;

    assign m_valid = valid_reg;
    assign m_char  = char_reg;
    assign m_last  = last_reg;

endmodule

>>> rtl/core/signed_decimal_field_formatter.sv
// Formats one signed 32-bit value per request as printf %d text and streams it out one
// ASCII character per result, with tlast on the final character; a field may be empty,
// in which case no result follows the request. The layout follows the configuration
// registers (width, precision, left adjust, zero fill, forced sign and its character),
// which the user must write through the cfg_wr port only while no request is in flight;
// the block itself does not enforce this. A request is prepared by a load, the 32-step
// bit-serial binary-to-BCD shift loop and a layout setup, followed by one output
// character per cycle through the single output register while the sink accepts them.
// The next request is taken as soon as the last character is in the output register.
module signed_decimal_field_formatter #(
    parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_out
    output logic        m_tlast
);
    import sdf_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    sdf_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    sdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdf_dp #(
        .MAX_FIELD (MAX_FIELD)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts),
        .s_value (s_tdata),
        .m_valid (m_tvalid),
        .m_char  (m_tdata),
        .m_last  (m_tlast),
        .m_ready (m_tready)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import sdf_pkg::*;

    localparam int FIELD_MAX   = MAX_FIELD_DEF;
    localparam int PREP_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } glyph_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_index;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] char_out
    logic        m_tlast;

    cfg_t   field_cfg;
    glyph_t expected_chars[$];
    int     mismatch_count = 0;
    int     quiet_cycles   = 0;
    int     rx_stall_left  = 0;
    bit     steady_mode    = 1'b0;
    bit     hold_pending   = 1'b0;

    signed_decimal_field_formatter #(
        .MAX_FIELD(FIELD_MAX)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void format_decimal_field(input logic [31:0] raw);
        logic [31:0] mag;
        logic [7:0]  digit[10];
        logic [7:0]  text[$];
        logic [7:0]  sign_char;
        bit          neg;
        bit          prec_given;
        bit          has_sign;
        int          prec;
        int          width;
        int          ndig;
        int          zeros;
        int          body;
        int          pad;
        neg        = raw[31];
        mag        = neg ? (~raw + 32'd1) : raw;
        prec_given = !field_cfg.precision[6];
        prec       = int'(field_cfg.precision[5:0]);
        if (prec > FIELD_MAX - 1) prec = FIELD_MAX - 1;
        width = int'(field_cfg.min_width);
        if (width > FIELD_MAX) width = FIELD_MAX;
        ndig = 0;
        if (!(prec_given && prec == 0 && mag == 0)) begin
            do begin
                digit[ndig] = CHAR_ZERO + 8'(mag % 32'd10);
                mag         = mag / 32'd10;
                ndig++;
            end while (mag != 0);
        end
        has_sign  = neg || field_cfg.sign_always;
        sign_char = neg ? CHAR_MINUS : field_cfg.positive_sign_char;
        zeros     = (prec_given && prec > ndig) ? prec - ndig : 0;
        body      = int'(has_sign) + zeros + ndig;
        pad       = (width > body) ? width - body : 0;
        if (!field_cfg.left_adjust && field_cfg.zero_fill && !prec_given) begin
            zeros += pad;
            pad    = 0;
        end
        if (!field_cfg.left_adjust) repeat (pad) text.push_back(CHAR_SPACE);
        if (has_sign) text.push_back(sign_char);
        repeat (zeros) text.push_back(CHAR_ZERO);
        for (int i = ndig - 1; i >= 0; i--) text.push_back(digit[i]);
        if (field_cfg.left_adjust) repeat (pad) text.push_back(CHAR_SPACE);
        while (text.size() > FIELD_MAX) void'(text.pop_back());
        foreach (text[i]) begin
            expected_chars.push_back('{ch: text[i], last: (i == text.size() - 1)});
        end
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            v = $urandom;
        end else if (r == 1) begin
            v = 32'($urandom_range(0, 40)) - 32'd20;
        end else if (r == 2) begin
            case ($urandom_range(0, 4))
                0: v = INT_MIN;
                1: v = INT_MAX;
                2: v = 32'hFFFF_FFFF;
                3: v = 32'd1;
                default: v = 32'd0;
            endcase
        end else begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = ~v + 32'd1;
        end
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("%0t: mismatch on %s: got 8'h%02h, want 8'h%02h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = steady_mode ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        format_decimal_field(v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (PREP_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_MIN_WIDTH:   field_cfg.min_width          = data[5:0];
            CFG_PRECISION:   field_cfg.precision          = data[6:0];
            CFG_LEFT_ADJUST: field_cfg.left_adjust        = data[0];
            CFG_ZERO_FILL:   field_cfg.zero_fill          = data[0];
            CFG_SIGN_ALWAYS: field_cfg.sign_always        = data[0];
            CFG_POS_SIGN:    field_cfg.positive_sign_char = data;
            default: ;
        endcase
    endtask

    // Every setting change also hits an unused index, which must leave the layout alone.
    task automatic configure(input logic [7:0] width, input logic [7:0] prec,
                             input logic [7:0] left, input logic [7:0] zfill,
                             input logic [7:0] force_sign, input logic [7:0] sign_char);
        drain();
        write_reg(CFG_MIN_WIDTH, width);
        write_reg(CFG_PRECISION, prec);
        write_reg(CFG_LEFT_ADJUST, left);
        write_reg(CFG_ZERO_FILL, zfill);
        write_reg(CFG_SIGN_ALWAYS, force_sign);
        write_reg(CFG_POS_SIGN, sign_char);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_value(32'd0);
        send_value(32'd7);
        send_value(32'hFFFF_FFFF);
        send_value(INT_MIN);
        send_value(INT_MAX);
    endtask

    task automatic test_empty_field();
        configure(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, CHAR_PLUS);
        send_value(32'd0);
        send_value(32'd5);
        configure(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, CHAR_SPACE);
        send_value(32'd0);
        send_value(-32'sd3);
    endtask

    task automatic test_padding_rules();
        configure(8'd12, {1'b0, PRECISION_NONE}, 8'd1, 8'd1, 8'd0, CHAR_PLUS);
        send_value(-32'sd42);
        configure(8'd12, {1'b0, PRECISION_NONE}, 8'd0, 8'd1, 8'd1, CHAR_PLUS);
        send_value(32'd42);
        send_value(INT_MIN);
        configure(8'd10, 8'd5, 8'd0, 8'd1, 8'd0, CHAR_PLUS);
        send_value(-32'sd7);
        configure(8'd6, {1'b0, PRECISION_NONE}, 8'd0, 8'd0, 8'd0, CHAR_PLUS);
        send_value(32'd31337);
    endtask

    task automatic test_saturation();
        configure(8'hFF, 8'h3F, 8'd0, 8'd0, 8'd1, 8'hFF);
        send_value(INT_MIN);
        send_value(32'd0);
        configure(8'd63, {1'b0, PRECISION_NONE}, 8'd1, 8'd0, 8'd0, CHAR_PLUS);
        send_value(32'd123);
        configure(8'd63, {1'b0, PRECISION_NONE}, 8'd0, 8'd1, 8'd0, CHAR_PLUS);
        send_value(32'hFFFF_FFFF);
    endtask

    task automatic test_random_settings();
        logic [7:0] width;
        logic [7:0] prec;
        logic [7:0] sign_char;
        int         r;
        for (int phase = 0; phase < 18; phase++) begin
            r = $urandom_range(0, 9);
            width = 8'($urandom);
            if (r < 7)      width[5:0] = 6'($urandom_range(0, 12));
            else if (r < 9) width[5:0] = 6'($urandom_range(13, 62));
            else            width[5:0] = 6'd63;
            prec = 8'($urandom);
            if ($urandom_range(0, 9) < 4) prec[6] = 1'b1;
            else begin
                prec[6]   = 1'b0;
                prec[5:0] = 6'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                                          : $urandom_range(13, 63));
            end
            case ($urandom_range(0, 3))
                0:       sign_char = CHAR_PLUS;
                1:       sign_char = CHAR_SPACE;
                default: sign_char = 8'($urandom);
            endcase
            configure(width, prec, 8'($urandom), 8'($urandom), 8'($urandom), sign_char);
            steady_mode = (phase % 6 == 5);
            repeat (11) send_value(random_value());
            steady_mode = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        configure(8'd8, {1'b0, PRECISION_NONE}, 8'd0, 8'd0, 8'd1, CHAR_PLUS);
        steady_mode  = 1'b1;
        hold_pending = 1'b1;
        repeat (12) send_value(random_value());
        steady_mode = 1'b0;
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (steady_mode) begin
                rx_stall_left = 0;
                m_tready <= 1'b1;
            end else if (rx_stall_left > 0) begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end else begin
                m_tready <= 1'b1;
                rx_stall_left = idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        glyph_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                flag_mismatch("character with no request pending", m_tdata, 8'h00);
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.ch) flag_mismatch("character", m_tdata, want.ch);
                if (m_tlast !== want.last) flag_mismatch("tlast", 8'(m_tlast), 8'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("signed_decimal_field_formatter verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= '0;
        cfg_wr_data  <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        field_cfg = '{min_width: 6'd0, precision: PRECISION_NONE, left_adjust: 1'b0,
                      zero_fill: 1'b0, sign_always: 1'b0, positive_sign_char: CHAR_PLUS};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_empty_field();
        test_padding_rules();
        test_saturation();
        test_random_settings();
        test_backpressure();
        drain();
        if (mismatch_count == 0) begin
            $display("signed_decimal_field_formatter verification clean");
        end else begin
            $display("signed_decimal_field_formatter verification failed");
        end
        $finish;
    end

endmodule
